// ----- sv/uart_oversampling_ratio_search_core_macros.svh -----
// ----------------------------------------------------------------------------
// uart oversampling ratio search: assertion macros
// Shared property wrappers, all clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef UART_OVERSAMPLING_RATIO_SEARCH_CORE_MACROS_SVH
`define UART_OVERSAMPLING_RATIO_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define RORS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RORS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rors_pkg.sv -----
// ----------------------------------------------------------------------------
// rors_pkg
// Widths, defaults and the job word that flows down the divider chains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rors_pkg;

    localparam int CLK_W  = 27;   // module clock in hertz
    localparam int BAUD_W = 24;   // requested baud rate
    localparam int OSR_W  = 5;    // osr register value
    localparam int SMP_W  = 6;    // samples per bit (osr + 1)
    localparam int DW     = 30;   // divisor width inside the chains
    localparam int QW     = CLK_W; // quotient bits, one per cell

    localparam int OSR_LOW_DEF  = 3;
    localparam int OSR_HIGH_DEF = 31;

    localparam logic [CLK_W-1:0] CLK_RESET = 27'd20971520;

    // one candidate job
    typedef struct packed {
        logic              valid;
        logic              first;   // first candidate of an item
        logic              last;    // last candidate of an item
        logic              skip;    // candidate not usable
        logic [OSR_W-1:0]  osr;
        logic [BAUD_W-1:0] baud;
        logic [DW-1:0]     d;       // current divisor
        logic [DW-1:0]     rem;     // partial remainder
        logic [QW-1:0]     q;       // quotient bits, later the baud error
    } job_t;

endpackage

// ----- sv/rors_div_cell.sv -----
// ----------------------------------------------------------------------------
// rors_div_cell
// One restoring division step: shifts in one dividend bit, makes one
// quotient bit and hands the job to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rors_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          num_bit,
    input  rors_pkg::job_t job_i,
    output rors_pkg::job_t job_o
);
    import rors_pkg::*;

    logic [DW:0] rem_sh;
    logic        ge;
    job_t        job_reg;
    job_t        job_next;

    // compare and conditional subtract
    always_comb begin
        rem_sh   = {job_i.rem, num_bit};
        ge       = (rem_sh >= {1'b0, job_i.d});
        job_next = job_i;
        job_next.rem = ge ? DW'(rem_sh - {1'b0, job_i.d}) : rem_sh[DW-1:0];
        job_next.q   = {job_i.q[QW-2:0], ge};
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg <= '0;
        end else if (adv) begin
            job_reg <= job_next;
        end
    end

    assign job_o = job_reg;

endmodule

// ----- sv/rors_issue.sv -----
// ----------------------------------------------------------------------------
// rors_issue
// Takes a baud rate word and issues one job per osr candidate, one a cycle while adv is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rors_issue #(
    parameter int OSR_LOW  = rors_pkg::OSR_LOW_DEF,
    parameter int OSR_HIGH = rors_pkg::OSR_HIGH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rors_pkg::BAUD_W-1:0] s_baud_rate,
    output rors_pkg::job_t              job_o
);
    import rors_pkg::*;

    localparam logic EMPTY = (OSR_LOW > OSR_HIGH);

    logic              busy_reg;
    logic              first_reg;
    logic [OSR_W-1:0]  osr_reg;
    logic [BAUD_W-1:0] baud_reg;
    logic              last;

    assign last    = (osr_reg == OSR_W'(OSR_HIGH)) || EMPTY;
    assign s_ready = adv && (!busy_reg || last);

    // outgoing job
    always_comb begin
        job_o       = '0;
        job_o.valid = busy_reg;
        job_o.first = first_reg;
        job_o.last  = last;
        job_o.skip  = (baud_reg == '0) || EMPTY;
        job_o.osr   = osr_reg;
        job_o.baud  = baud_reg;
    end

    // candidate counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            osr_reg   <= '0;
        end else if (adv) begin
            if (busy_reg) begin
                first_reg <= 1'b0;
                if (last) begin
                    busy_reg <= 1'b0;
                end else begin
                    osr_reg <= osr_reg + 1'b1;
                end
            end
            if (s_valid && s_ready) begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                osr_reg   <= OSR_W'(OSR_LOW);
            end
        end
    end

    // captured word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            baud_reg <= s_baud_rate;
        end
    end

endmodule

// ----- sv/rors_reduce.sv -----
// ----------------------------------------------------------------------------
// rors_reduce
// Keeps the smallest baud error over an item's candidates and holds the
// result word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rors_reduce (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rors_pkg::job_t             job_i,
    output logic                       adv,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rors_pkg::OSR_W-1:0] m_best_osr,
    output logic                       m_error
);
    import rors_pkg::*;

    logic             found_reg;
    logic [QW-1:0]    best_err_reg;
    logic [OSR_W-1:0] best_reg;
    logic             m_valid_reg;
    logic [OSR_W-1:0] best_osr_reg;
    logic             error_reg;
    logic             found_eff;
    logic             take;
    logic             found_new;
    logic [OSR_W-1:0] best_new;

    // hold only when a finished item meets a result word still waiting
    assign adv = !(job_i.valid && job_i.last && m_valid_reg && !m_ready);

    // running minimum, lowest osr wins ties
    always_comb begin
        found_eff = job_i.first ? 1'b0 : found_reg;
        take      = !job_i.skip && (!found_eff || (job_i.q < best_err_reg));
        found_new = found_eff || !job_i.skip;
        best_new  = take ? job_i.osr : best_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (adv && job_i.valid) begin
            found_reg <= found_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && job_i.valid && take) begin
            best_err_reg <= job_i.q;
            best_reg     <= job_i.osr;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (adv && job_i.valid && job_i.last) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && job_i.valid && job_i.last) begin
            best_osr_reg <= found_new ? best_new : '0;
            error_reg    <= !found_new;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_best_osr = best_osr_reg;
    assign m_error    = error_reg;

endmodule

// ----- sv/uart_oversampling_ratio_search_core.sv -----
// ----------------------------------------------------------------------------
// uart_oversampling_ratio_search_core
// Finds the oversampling ratio giving the closest achievable baud rate.
// ----------------------------------------------------------------------------
// Usage: write the module clock in hertz through cfg_wr_en / cfg_wr_data
// while idle (reset value 20971520). Offer a requested baud rate word on
// s_valid / s_ready / s_baud_rate; one result word comes back on m_valid /
// m_ready with m_best_osr and m_error.
// Every osr candidate becomes one job: divisor = clock / (baud * (osr + 1))
// and achieved rate = clock / (divisor * (osr + 1)), each quotient formed by
// a row of 27 restoring division cells, one bit per cell.
// Words overlap: a new word is taken as the last candidate of the one
// before is issued, so the input rate is set by the candidate issue rate.
// A job passes m1_reg, chain1, m2_reg, chain2, e_reg, then the result register.
// Reset clears all job valid bits and the result valid flag; the clock
// register returns to its reset value.
// When the receiver stalls, the chains keep running and new words are
// accepted until the next item's last candidate reaches the waiting result
// register; then the whole pipeline and the input hold.
// m_error is set, with m_best_osr zero, for a zero baud rate, an empty osr
// range, or when every candidate has a zero divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_oversampling_ratio_search_core #(
    parameter int OSR_LOW  = rors_pkg::OSR_LOW_DEF,
    parameter int OSR_HIGH = rors_pkg::OSR_HIGH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rors_pkg::CLK_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rors_pkg::BAUD_W-1:0] s_baud_rate,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rors_pkg::OSR_W-1:0]  m_best_osr,
    output logic                        m_error
);
    import rors_pkg::*;

    `include "uart_oversampling_ratio_search_core_macros.svh"

    logic [CLK_W-1:0] clock_hz_reg;
    logic             adv;
    job_t             issue_job;
    job_t             m1_reg, m1_next;
    job_t             m2_reg, m2_next;
    job_t             e_reg, e_next;
    job_t             chain1 [QW+1];
    job_t             chain2 [QW+1];
    logic [SMP_W-1:0] smp1;
    logic [SMP_W-1:0] smp2;

    // clock register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLK_RESET;
        end else if (cfg_wr_en) begin
            clock_hz_reg <= cfg_wr_data;
        end
    end

    rors_issue #(
        .OSR_LOW  (OSR_LOW),
        .OSR_HIGH (OSR_HIGH)
    ) u_issue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_baud_rate (s_baud_rate),
        .job_o       (issue_job)
    );

    // first divisor: baud times samples per bit
    always_comb begin
        smp1      = SMP_W'(issue_job.osr) + 1'b1;
        m1_next   = issue_job;
        m1_next.d = DW'(issue_job.baud * smp1);
        m1_next.rem = '0;
        m1_next.q   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_reg <= '0;
        end else if (adv) begin
            m1_reg <= m1_next;
        end
    end

    assign chain1[0] = m1_reg;

    // baud divisor chain
    for (genvar i = 0; i < QW; i++) begin : g_chain1
        rors_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .num_bit (clock_hz_reg[QW-1-i]),
            .job_i   (chain1[i]),
            .job_o   (chain1[i+1])
        );
    end

    // second divisor: baud divisor times samples, zero divisor skipped
    always_comb begin
        smp2         = SMP_W'(chain1[QW].osr) + 1'b1;
        m2_next      = chain1[QW];
        m2_next.skip = chain1[QW].skip || (chain1[QW].q == '0);
        m2_next.d    = DW'(chain1[QW].q * smp2);
        m2_next.rem  = '0;
        m2_next.q    = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_reg <= '0;
        end else if (adv) begin
            m2_reg <= m2_next;
        end
    end

    assign chain2[0] = m2_reg;

    // achieved baud rate chain
    for (genvar i = 0; i < QW; i++) begin : g_chain2
        rors_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .num_bit (clock_hz_reg[QW-1-i]),
            .job_i   (chain2[i]),
            .job_o   (chain2[i+1])
        );
    end

    // absolute baud error
    always_comb begin
        e_next = chain2[QW];
        if (QW'(chain2[QW].baud) > chain2[QW].q) begin
            e_next.q = QW'(chain2[QW].baud) - chain2[QW].q;
        end else begin
            e_next.q = chain2[QW].q - QW'(chain2[QW].baud);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg <= '0;
        end else if (adv) begin
            e_reg <= e_next;
        end
    end

    rors_reduce u_reduce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_i      (e_reg),
        .adv        (adv),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_best_osr (m_best_osr),
        .m_error    (m_error)
    );

    // checks
    `RORS_ASSERT_NOW(a_err_zero, m_valid && m_error, m_best_osr == '0, "error with nonzero osr")
    `RORS_ASSERT_NOW(a_osr_range, m_valid && !m_error,
        (m_best_osr >= OSR_W'(OSR_LOW)) && (m_best_osr <= OSR_W'(OSR_HIGH)), "osr out of range")
    `RORS_ASSERT_NOW(a_ready_adv, s_ready, adv, "input taken while pipeline held")
    `RORS_ASSERT_NEXT(a_hold, !adv, $stable(e_reg), "pipeline moved while held")

endmodule

// ----- tb/tb_uart_oversampling_ratio_search_core.sv -----
// ----------------------------------------------------------------------------
// tb_uart_oversampling_ratio_search_core
// Drives requested baud rates under several clock settings and idling
// patterns, predicts the best osr per word and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_oversampling_ratio_search_core;

    import rors_pkg::*;

    localparam int OSR_MIN = OSR_LOW_DEF;
    localparam int OSR_MAX = OSR_HIGH_DEF;
    localparam int SETTLE  = 200;

    typedef struct {
        logic [OSR_W-1:0] osr;
        logic             err;
    } osr_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CLK_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [BAUD_W-1:0]   s_baud_rate;
    logic                m_valid;
    logic                m_ready;
    logic [OSR_W-1:0]    m_best_osr;
    logic                m_error;

    logic [CLK_W-1:0]    model_clock_hz;
    logic [BAUD_W-1:0]   baud_pending_q[$];
    osr_result_t         osr_expected_q[$];
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_off_cycles;
    int                  mismatch_count;
    int                  words_sent;
    int                  words_checked;
    int                  error_words;

    uart_oversampling_ratio_search_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_baud_rate (s_baud_rate),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_best_osr  (m_best_osr),
        .m_error     (m_error)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // best osr search at full width, lowest osr wins ties
    function automatic osr_result_t search_best_osr(logic [CLK_W-1:0] clk_hz,
                                                    logic [BAUD_W-1:0] baud);
        osr_result_t res;
        logic [63:0] per_bit;
        logic [63:0] divisor;
        logic [63:0] actual;
        logic [63:0] err_abs;
        logic [63:0] best_err;
        bit          found;
        res.osr = '0;
        res.err = 1'b1;
        found = 0;
        best_err = '0;
        if (baud != 0) begin
            per_bit = 64'(clk_hz) / 64'(baud);
            for (int osr = OSR_MIN; osr <= OSR_MAX; osr++) begin
                divisor = per_bit / 64'(osr + 1);
                if (divisor != 0) begin
                    actual = 64'(clk_hz) / (divisor * 64'(osr + 1));
                    err_abs = (64'(baud) > actual) ? 64'(baud) - actual
                                                   : actual - 64'(baud);
                    if (!found || err_abs < best_err) begin
                        found = 1;
                        best_err = err_abs;
                        res.osr = OSR_W'(osr);
                        res.err = 1'b0;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on word %0d: %s got %0d expected %0d",
                 words_checked, what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                osr_expected_q.push_back(search_best_osr(model_clock_hz, s_baud_rate));
                words_sent++;
            end
            if (baud_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid     <= 1'b1;
                s_baud_rate <= baud_pending_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        osr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (osr_expected_q.size() == 0) begin
                report_mismatch("unexpected word, osr", m_best_osr, -1);
            end else begin
                want = osr_expected_q.pop_front();
                if (m_best_osr !== want.osr)
                    report_mismatch("best_osr", m_best_osr, want.osr);
                if (m_error !== want.err)
                    report_mismatch("error", m_error, want.err);
                if (want.err)
                    error_words++;
            end
            words_checked++;
        end
    end

    // wait until every queued word has been sent and answered
    task automatic drain();
        while (baud_pending_q.size() != 0 || s_valid || osr_expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_clock(logic [CLK_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_clock_hz = value;
    endtask

    // baud rates mostly in a range that gives usable divisors
    function automatic logic [BAUD_W-1:0] random_baud();
        case ($urandom_range(9))
            0:       return BAUD_W'($urandom);
            1:       return BAUD_W'($urandom_range(16));
            2:       return BAUD_W'(model_clock_hz / ($urandom_range(40) + 1));
            default: return BAUD_W'($urandom_range(1, 3000000));
        endcase
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) baud_pending_q.push_back(random_baud());
        drain();
    endtask

    // stimulus
    initial begin
        logic [CLK_W-1:0] clock_set[6];
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_baud_rate    = '0;
        m_ready        = 1'b0;
        model_clock_hz = CLK_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        mismatch_count = 0;
        words_sent     = 0;
        words_checked  = 0;
        error_words    = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at the reset clock
        foreach (clock_set[i]) clock_set[i] = '0;
        baud_pending_q = '{24'd0, 24'd1, 24'hFFFFFF, 24'd9600, 24'd115200,
                           24'd921600, 24'd5242880, 24'd5242881, 24'd655360,
                           24'hAAAAAA, 24'h555555, 24'd300};
        drain();

        // clock extremes, including zero and all ones
        foreach (clock_set[i]) ;
        clock_set = '{27'd0, 27'd1, 27'h7FFFFFF, 27'h5555555, 27'h2AAAAAA, 27'd48000000};
        foreach (clock_set[i]) begin
            write_clock(clock_set[i]);
            baud_pending_q = '{24'd0, 24'd1, 24'd2, 24'hFFFFFF, 24'd115200};
            drain();
        end

        // random phases over several clocks and idling patterns
        write_clock(27'd48000000);
        random_phase(80, 0, 0);
        write_clock(27'($urandom));
        random_phase(80, 70, 0);
        write_clock(27'd20971520);
        random_phase(80, 0, 70);
        write_clock(27'($urandom_range(1000000, 134217727)));
        random_phase(80, 30, 30);

        // long receiver hold-off so the block backs up its input
        write_clock(27'h7FFFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 600;
        repeat (40) baud_pending_q.push_back(random_baud());
        drain();

        // sender pauses until all results are back, then goes on
        random_phase(30, 0, 30);
        random_phase(30, 30, 0);

        $display("covered %0d words, %0d flagged as error, across clock settings from 0 to max",
                 words_checked, error_words);
        $display("idling phases: none, sender, receiver, both, plus a long receiver hold-off");
        if (mismatch_count == 0 && words_checked == words_sent) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
